@@ src/sacp_pkg.sv @@
// Shared types and constant tables for the four-way set-associative cache tracker.
// Used by sacp_lookup and set_assoc_cache_plru_tracker_unit; no dependencies.
`timescale 1ns / 1ps

package sacp_pkg;

   localparam int WAYS     = 4;
   localparam int WAY_W    = 2;
   localparam int PLRU_W   = 3;
   localparam int COUNT_W  = 32;

   // Access kind on req_operation
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Victim way for each tree PLRU state
   localparam logic [WAY_W-1:0] PLRU_VICTIM [8] = '{
      2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3
   };

   // Next PLRU state, indexed by {state, way used}
   localparam logic [PLRU_W-1:0] PLRU_NEXT [32] = '{
      3'd6, 3'd4, 3'd1, 3'd0, 3'd7, 3'd5, 3'd1, 3'd0,
      3'd6, 3'd4, 3'd3, 3'd2, 3'd7, 3'd5, 3'd3, 3'd2,
      3'd6, 3'd4, 3'd1, 3'd0, 3'd7, 3'd5, 3'd1, 3'd0,
      3'd6, 3'd4, 3'd3, 3'd2, 3'd7, 3'd5, 3'd3, 3'd2
   };

   // Outcome of one lookup
   typedef struct packed {
      logic             hit;
      logic [WAY_W-1:0] way;
      logic             write_back;
   } sacp_result_type;

endpackage

@@ src/sacp_lookup.sv @@
// Tag compare, victim choice and row update for one set.
// Depends on sacp_pkg for the PLRU tables and the result struct.
`timescale 1ns / 1ps

module sacp_lookup #(
   parameter int TAG_W = 9
) (
   input  logic [TAG_W-1:0]                               tag,
   input  logic                                           operation,
   input  logic [sacp_pkg::WAYS*(TAG_W+2)+sacp_pkg::PLRU_W-1:0] row_in,
   output logic [sacp_pkg::WAYS*(TAG_W+2)+sacp_pkg::PLRU_W-1:0] row_out,
   output sacp_pkg::sacp_result_type                      result
);

   // Row layout: way w at [w*LINE_W +: LINE_W] as {valid, dirty, tag}, PLRU on top
   localparam int LINE_W = TAG_W + 2;
   localparam int PLRU_LSB = sacp_pkg::WAYS * LINE_W;

   logic [sacp_pkg::WAYS-1:0]    vld;
   logic [sacp_pkg::WAYS-1:0]    drt;
   logic [sacp_pkg::WAYS-1:0]    match;
   logic [sacp_pkg::PLRU_W-1:0]  plru;
   logic                         hit;
   logic                         any_free;
   logic [sacp_pkg::WAY_W-1:0]   hit_way;
   logic [sacp_pkg::WAY_W-1:0]   free_way;
   logic [sacp_pkg::WAY_W-1:0]   way;

   always_comb begin
      for (int w = 0; w < sacp_pkg::WAYS; w++) begin
         vld[w]   = row_in[w*LINE_W + TAG_W + 1];
         drt[w]   = row_in[w*LINE_W + TAG_W];
         match[w] = vld[w] && (row_in[w*LINE_W +: TAG_W] == tag);
      end
      plru = row_in[PLRU_LSB +: sacp_pkg::PLRU_W];
   end

   // Lowest-numbered way wins: scan from the top down
   always_comb begin
      hit      = 1'b0;
      any_free = 1'b0;
      hit_way  = '0;
      free_way = '0;
      for (int w = sacp_pkg::WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit     = 1'b1;
            hit_way = sacp_pkg::WAY_W'(w);
         end
         if (!vld[w]) begin
            any_free = 1'b1;
            free_way = sacp_pkg::WAY_W'(w);
         end
      end
   end

   always_comb begin
      priority if (hit) begin
         way = hit_way;
      end else if (any_free) begin
         way = free_way;
      end else begin
         way = sacp_pkg::PLRU_VICTIM[plru];
      end
   end

   always_comb begin
      result.hit        = hit;
      result.way        = way;
      result.write_back = !hit && vld[way] && drt[way];

      row_out = row_in;
      if (!hit) begin
         row_out[int'(way)*LINE_W +: LINE_W] = {1'b1, 1'b0, tag};
      end
      if (operation == sacp_pkg::OP_WRITE) begin
         row_out[int'(way)*LINE_W + TAG_W] = 1'b1;
      end
      row_out[PLRU_LSB +: sacp_pkg::PLRU_W] = sacp_pkg::PLRU_NEXT[{plru, way}];
   end

endmodule

@@ src/set_assoc_cache_plru_tracker_unit.sv @@
// Four-way set-associative cache tag tracker with tree PLRU replacement, top level.
// Holds the set memory, the lookup stage, the counters and the response register.
// Depends on sacp_pkg and sacp_lookup.
//
//   channel | direction | words                               | handshake
//   req     | in        | address, operation                  | req_valid / req_stall
//   rsp     | out       | hit, way, write_back, five counters | rsp_valid / rsp_stall
//
// One access per cycle sustained while rsp_stall is low; after acceptance a response word
// passes the set memory read, then lookup and write-back into the response register.
// Back-to-back accesses to one set are forwarded from the write-back path.
// After reset a clearing pass zeroes the set memory, one set a cycle, with req_stall high.
// rsp_stall holds the response register and, once the lookup stage is full, raises req_stall.
`timescale 1ns / 1ps

module set_assoc_cache_plru_tracker_unit #(
   parameter int NUM_SETS    = 16,
   parameter int OFFSET_BITS = 3,
   parameter int ADDR_BITS   = 16
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ADDR_BITS-1:0]             req_address,
   input  logic                             req_operation,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_hit,
   output logic [sacp_pkg::WAY_W-1:0]       rsp_way,
   output logic                             rsp_write_back,
   output logic [sacp_pkg::COUNT_W-1:0]     rsp_read_count,
   output logic [sacp_pkg::COUNT_W-1:0]     rsp_write_count,
   output logic [sacp_pkg::COUNT_W-1:0]     rsp_hit_count,
   output logic [sacp_pkg::COUNT_W-1:0]     rsp_miss_count,
   output logic [sacp_pkg::COUNT_W-1:0]     rsp_writeback_count
);

   localparam int IDX_W   = $clog2(NUM_SETS);
   localparam int TAG_RAW = ADDR_BITS - OFFSET_BITS - IDX_W;
   localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
   localparam int ROW_W   = sacp_pkg::WAYS * (TAG_W + 2) + sacp_pkg::PLRU_W;
   localparam int CW      = sacp_pkg::COUNT_W;

   logic [IDX_W-1:0]  req_set;
   logic [TAG_W-1:0]  req_tag;
   logic              req_accept;

   logic              clr_active_ff;
   logic [IDX_W-1:0]  clr_idx_ff;

   logic [ROW_W-1:0]  set_mem [NUM_SETS];
   logic [ROW_W-1:0]  rd_row_ff;
   logic [ROW_W-1:0]  fwd_row_ff;
   logic              fwd_sel_ff;

   logic              s1_valid_ff;
   logic [IDX_W-1:0]  s1_set_ff;
   logic [TAG_W-1:0]  s1_tag_ff;
   logic              s1_op_ff;
   logic              s1_adv;
   logic              s1_fire;
   logic [ROW_W-1:0]  s1_row;
   logic [ROW_W-1:0]  s1_row_new;

   sacp_pkg::sacp_result_type s1_result;

   logic [CW-1:0] read_cnt_ff, write_cnt_ff, hit_cnt_ff, miss_cnt_ff, wb_cnt_ff;
   logic [CW-1:0] read_cnt_in, write_cnt_in, hit_cnt_in, miss_cnt_in, wb_cnt_in;

   logic              rsp_valid_ff;
   sacp_pkg::sacp_result_type rsp_result_ff;
   logic [CW-1:0] rsp_read_ff, rsp_write_ff, rsp_hit_cnt_ff, rsp_miss_ff, rsp_wb_ff;

   // Address split; shifts keep every parameter corner in range
   assign req_set = IDX_W'(req_address >> OFFSET_BITS) & IDX_W'(NUM_SETS - 1);
   assign req_tag = TAG_W'(req_address >> (OFFSET_BITS + IDX_W));

   assign s1_adv     = !rsp_valid_ff || !rsp_stall;
   assign s1_fire    = s1_valid_ff && s1_adv;
   assign req_stall  = clr_active_ff || (s1_valid_ff && !s1_adv);
   assign req_accept = req_valid && !req_stall;

   // Clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_idx_ff    <= '0;
      end else if (clr_active_ff) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
         if (clr_idx_ff == IDX_W'(NUM_SETS - 1)) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   // Set memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         set_mem[clr_idx_ff] <= '0;
      end else if (s1_fire) begin
         set_mem[s1_set_ff] <= s1_row_new;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_row_ff  <= set_mem[req_set];
         fwd_row_ff <= s1_row_new;
      end
   end

   // Read returns the old row when the previous word writes the same set
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_sel_ff <= 1'b0;
      end else if (req_accept) begin
         fwd_sel_ff <= s1_fire && (s1_set_ff == req_set);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_set_ff <= req_set;
         s1_tag_ff <= req_tag;
         s1_op_ff  <= req_operation;
      end
   end

   assign s1_row = fwd_sel_ff ? fwd_row_ff : rd_row_ff;

   sacp_lookup #(
      .TAG_W (TAG_W)
   ) u_lookup (
      .tag       (s1_tag_ff),
      .operation (s1_op_ff),
      .row_in    (s1_row),
      .row_out   (s1_row_new),
      .result    (s1_result)
   );

   always_comb begin
      read_cnt_in  = read_cnt_ff  + CW'(s1_op_ff == sacp_pkg::OP_READ);
      write_cnt_in = write_cnt_ff + CW'(s1_op_ff == sacp_pkg::OP_WRITE);
      hit_cnt_in   = hit_cnt_ff   + CW'(s1_result.hit);
      miss_cnt_in  = miss_cnt_ff  + CW'(!s1_result.hit);
      wb_cnt_in    = wb_cnt_ff    + CW'(s1_result.write_back);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_cnt_ff  <= '0;
         write_cnt_ff <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         wb_cnt_ff    <= '0;
      end else if (s1_fire) begin
         read_cnt_ff  <= read_cnt_in;
         write_cnt_ff <= write_cnt_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         wb_cnt_ff    <= wb_cnt_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_result_ff  <= s1_result;
         rsp_read_ff    <= read_cnt_in;
         rsp_write_ff   <= write_cnt_in;
         rsp_hit_cnt_ff <= hit_cnt_in;
         rsp_miss_ff    <= miss_cnt_in;
         rsp_wb_ff      <= wb_cnt_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit             = rsp_result_ff.hit;
   assign rsp_way             = rsp_result_ff.way;
   assign rsp_write_back      = rsp_result_ff.write_back;
   assign rsp_read_count      = rsp_read_ff;
   assign rsp_write_count     = rsp_write_ff;
   assign rsp_hit_count       = rsp_hit_cnt_ff;
   assign rsp_miss_count      = rsp_miss_ff;
   assign rsp_writeback_count = rsp_wb_ff;

   // Every access is either a hit or a miss
   a_count_balance: assert property (@(posedge clock) disable iff (reset)
      CW'(hit_cnt_ff + miss_cnt_ff) == CW'(read_cnt_ff + write_cnt_ff))
      else $error("hit plus miss count differs from access count");

   // No word in the lookup stage while the memory is being cleared
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !s1_valid_ff)
      else $error("lookup stage busy during clearing pass");

   // A hit never evicts
   a_hit_no_wb: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> !(s1_result.hit && s1_result.write_back))
      else $error("write-back flagged on a hit");

   // A held lookup keeps its set until it moves on
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_set_ff))
      else $error("stalled lookup lost its set");

endmodule
